[hw/rtl/uidq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_pkg
// Shared sizes, command and status codes and the result record of the
// unique id fifo queue.
// ----------------------------------------------------------------------------
package uidq_pkg;

   // store size and derived widths
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // commands
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

   // one result record
   typedef struct packed {
      logic [COUNT_W-1:0]  entry_count;
      logic [ID_W-1:0]     head_id;
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

[hw/rtl/uidq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module uidq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/uidq_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_engine
// Command sequencer: scans the id store one entry a cycle through a single
// comparator, appends at the tail, and closes gaps by copying entries down.
// ----------------------------------------------------------------------------
module uidq_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [uidq_pkg::CMD_W-1:0]   cmd,
   input  logic [uidq_pkg::ID_W-1:0]    id,
   output logic                         idle,
   input  logic                         slot_free,
   output logic                         done,
   output uidq_pkg::result_type         result
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [uidq_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [uidq_pkg::ID_W-1:0]        id_ff, id_in;
   logic [uidq_pkg::CNT_W-1:0]       len_ff, len_in;
   logic [uidq_pkg::CNT_W-1:0]       scan_ff, scan_in;
   logic                             cmp_vld_ff, cmp_vld_in;
   logic [uidq_pkg::IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                             pend_ff, pend_in;
   logic                             pend_head_ff, pend_head_in;
   logic [uidq_pkg::IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [uidq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [uidq_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [uidq_pkg::ID_W-1:0]        head_ff, head_in;

   logic                             ram_we;
   logic [uidq_pkg::IDX_W-1:0]       ram_waddr;
   logic [uidq_pkg::ID_W-1:0]        ram_wdata;
   logic [uidq_pkg::IDX_W-1:0]       ram_raddr;
   logic [uidq_pkg::ID_W-1:0]        ram_rdata;
   logic                             match;

   uidq_ram #(
      .WIDTH (uidq_pkg::ID_W),
      .DEPTH (uidq_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // the read address always follows the scan / copy pointer
   assign ram_raddr = scan_ff[uidq_pkg::IDX_W-1:0];
   // shared comparator against the entry read last cycle
   assign match     = cmp_vld_ff && (ram_rdata == id_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      pend_in      = pend_ff;
      pend_head_in = pend_head_ff;
      wr_idx_in    = wr_idx_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_idx_ff;
      ram_wdata    = ram_rdata;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = cmd;
               id_in      = id;
               status_in  = uidq_pkg::STAT_OK;
               pos_in     = '0;
               head_in    = '0;
               scan_in    = '0;
               cmp_vld_in = 1'b0;
               pend_in    = 1'b0;
               if (cmd == uidq_pkg::CMD_POP) begin
                  if (len_ff == '0) begin
                     status_in = uidq_pkg::STAT_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SHIFT;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (match) begin
               case (cmd_ff)
                  uidq_pkg::CMD_APPEND: begin
                     status_in = uidq_pkg::STAT_DUP;
                     state_in  = S_DONE;
                  end
                  uidq_pkg::CMD_REMOVE: begin
                     pos_in   = cmp_idx_ff;
                     scan_in  = uidq_pkg::CNT_W'(cmp_idx_ff) + 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT;
                  end
                  default: begin
                     pos_in   = cmp_idx_ff;
                     state_in = S_DONE;
                  end
               endcase
            end else if (scan_ff == len_ff) begin
               // every queued entry compared, no hit
               state_in = S_DONE;
               if (cmd_ff == uidq_pkg::CMD_APPEND) begin
                  if (len_ff >= uidq_pkg::CNT_W'(uidq_pkg::QUEUE_DEPTH)) begin
                     status_in = uidq_pkg::STAT_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = len_ff[uidq_pkg::IDX_W-1:0];
                     ram_wdata = id_ff;
                     len_in    = len_ff + 1'b1;
                  end
               end else begin
                  status_in = uidq_pkg::STAT_NOT_FOUND;
               end
            end else begin
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[uidq_pkg::IDX_W-1:0];
            end
         end
         S_SHIFT: begin
            // land the beat read last cycle: head capture or copy down
            if (pend_ff) begin
               if (pend_head_ff) begin
                  head_in = ram_rdata;
               end else begin
                  ram_we = 1'b1;
               end
            end
            if (scan_ff < len_ff) begin
               pend_in      = 1'b1;
               pend_head_in = (scan_ff == '0);
               wr_idx_in    = uidq_pkg::IDX_W'(scan_ff - 1'b1);
               scan_in      = scan_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               len_in   = len_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         len_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         cmp_vld_ff <= cmp_vld_in;
         pend_ff    <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      pend_head_ff <= pend_head_in;
      wr_idx_ff    <= wr_idx_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      head_ff      <= head_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);

   always_comb begin
      result.status      = status_ff;
      result.position    = uidq_pkg::POS_W'(pos_ff);
      result.head_id     = head_ff;
      result.entry_count = uidq_pkg::COUNT_W'(len_ff);
   end

   // store writes only happen while scanning or copying
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN || state_ff == S_SHIFT))
      else $error("store written outside scan or copy");

   // count never passes the store size
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= uidq_pkg::CNT_W'(uidq_pkg::QUEUE_DEPTH))
      else $error("entry count above store size");

   // count changes only on the way into the result state
   assert property (@(posedge clock) disable iff (reset)
      (len_ff != $past(len_ff)) |-> (state_ff == S_DONE && $past(state_ff) != S_DONE))
      else $error("entry count changed outside command completion");

   // a finished result waits until the output slot takes it
   assert property (@(posedge clock) disable iff (reset)
      (done && !slot_free) |=> (done && $stable(result)))
      else $error("result dropped or changed while waiting");

endmodule

[hw/rtl/unique_id_fifo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_fifo_queue
// Ordered queue of unique 16-bit ids with append, remove by id, pop and
// position query; one result beat for every command beat.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  req     | in  | command[1:0], plane_id[17:2]
//  rsp     | out | status[2:0], position[6:3], head_id[22:7], entry_count[27:23]
//
//  A command holds the sequencer from the accept state through a search of
//  one entry a cycle through the single comparator, behind the registered
//  store read, up to the hit or the tail; then a remove copies down the
//  entries behind the hit, a pop walks the whole queue without a search,
//  and finally the sequencer holds the result in its result state.
//  req_tready is high only while the sequencer is idle.
//  The result sits in an output register, so the next command is taken while
//  a result waits for rsp_tready; a second result waits in the sequencer.
//  Reset clears the count, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module unique_id_fifo_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // command[1:0], plane_id[17:2], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status, position, head_id, entry_count, zero
);

   logic                          idle;
   logic                          done;
   logic                          slot_free;
   logic                          start;
   uidq_pkg::result_type          result;
   logic                          rsp_valid_ff, rsp_valid_in;
   uidq_pkg::result_type          rsp_data_ff, rsp_data_in;

   // input beat accept
   assign req_tready = idle;
   assign start      = req_tvalid && idle;

   uidq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req_tdata[1:0]),
      .id        (req_tdata[17:2]),
      .idle      (idle),
      .slot_free (slot_free),
      .done      (done),
      .result    (result)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

[dv/unique_id_fifo_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_fifo_queue_test
// Self-checking bench for the unique id fifo queue. A directed opening walks
// the empty, duplicate, full and gap-closing cases, then weighted random
// phases of fill, drain and even command mixes run against a behavioral
// model of the ordered id store. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module unique_id_fifo_queue_test;

   localparam int RANDOM_COMMANDS = 924;
   localparam int ID_POOL_SIZE    = 20;
   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int TAIL_CYCLES     = 2 * uidq_pkg::QUEUE_DEPTH + 8;

   typedef struct {
      logic [uidq_pkg::CMD_W-1:0] command;
      logic [uidq_pkg::ID_W-1:0]  plane_id;
      bit                         drain_first;
   } queue_cmd_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_THIRD, READY_MOSTLY} ready_mode_type;
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // command[1:0], plane_id[17:2], zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // status, position, head_id, entry_count, zero

   queue_cmd_type             pending_cmds[$];
   uidq_pkg::result_type      expected_results[$];
   logic [uidq_pkg::ID_W-1:0] queued_model[$];
   logic [uidq_pkg::ID_W-1:0] id_pool[ID_POOL_SIZE];

   int status_hits[0:(1 << uidq_pkg::STATUS_W) - 1];
   int results_seen;
   int commands_taken;
   int mismatch_count;
   int idle_cycles;
   int deepest_queue;
   bit req_accepted;

   // sender burst state
   int burst_left = 1;
   int gap_left;

   // receiver stall state
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_mode_left;
   int             hold_left;
   bit             hold_done;
   int             cycle_count;

   unique_id_fifo_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // behavioral store: applies one command, returns the result it gives
   function automatic uidq_pkg::result_type apply_queue_command(
         logic [uidq_pkg::CMD_W-1:0] command,
         logic [uidq_pkg::ID_W-1:0]  plane_id);
      uidq_pkg::result_type outcome;
      int                   place;
      outcome        = '0;
      outcome.status = uidq_pkg::STAT_OK;
      place          = queued_model.size();
      foreach (queued_model[i]) begin
         if (queued_model[i] == plane_id && place == queued_model.size())
            place = i;
      end
      case (command)
         uidq_pkg::CMD_APPEND: begin
            // duplicate wins over full
            if (place < queued_model.size())
               outcome.status = uidq_pkg::STAT_DUP;
            else if (queued_model.size() >= uidq_pkg::QUEUE_DEPTH)
               outcome.status = uidq_pkg::STAT_FULL;
            else
               queued_model.push_back(plane_id);
         end
         uidq_pkg::CMD_REMOVE: begin
            if (place >= queued_model.size()) begin
               outcome.status = uidq_pkg::STAT_NOT_FOUND;
            end else begin
               outcome.position = uidq_pkg::POS_W'(place);
               queued_model.delete(place);
            end
         end
         uidq_pkg::CMD_POP: begin
            if (queued_model.size() == 0)
               outcome.status = uidq_pkg::STAT_EMPTY;
            else
               outcome.head_id = queued_model.pop_front();
         end
         default: begin
            if (place >= queued_model.size())
               outcome.status = uidq_pkg::STAT_NOT_FOUND;
            else
               outcome.position = uidq_pkg::POS_W'(place);
         end
      endcase
      outcome.entry_count = uidq_pkg::COUNT_W'(queued_model.size());
      return outcome;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void add_command(logic [uidq_pkg::CMD_W-1:0] command,
                                       logic [uidq_pkg::ID_W-1:0]  plane_id,
                                       bit drain_first);
      queue_cmd_type item;
      item.command     = command;
      item.plane_id    = plane_id;
      item.drain_first = drain_first;
      pending_cmds.push_back(item);
   endfunction

   // request driver: holds a beat until taken, bursts with random gaps
   always @(negedge clock) begin : driver
      queue_cmd_type next_cmd;
      bit            present;
      present = req_tvalid && !req_accepted;
      if (!reset && !present) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_cmds.size() != 0 &&
                      !(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
            next_cmd  = pending_cmds.pop_front();
            req_tdata <= {6'b0, next_cmd.plane_id, next_cmd.command};
            present   = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
      req_tvalid <= present;
   end

   // result receiver: changing stall patterns plus one long hold-off
   always @(negedge clock) begin : receiver
      bit ready;
      cycle_count++;
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(20, 120);
      end else begin
         ready_mode_left--;
      end
      if (!hold_done && results_seen >= HOLD_OFF_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
      end
      case (ready_mode)
         READY_ALWAYS: ready = 1'b1;
         READY_COIN:   ready = $urandom_range(0, 1);
         READY_THIRD:  ready = (cycle_count % 3 == 0);
         default:      ready = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
         hold_left--;
         ready = 1'b0;
      end
      rsp_tready <= ready && !reset;
   end

   // monitor: checks result beats, predicts on command beats, watchdog
   always @(posedge clock) begin : monitor
      uidq_pkg::result_type got;
      uidq_pkg::result_type want;
      bit                   moved;
      moved        = 1'b0;
      req_accepted = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            got = uidq_pkg::result_type'(rsp_tdata[$bits(uidq_pkg::result_type)-1:0]);
            if (expected_results.size() == 0) begin
               $error("result beat with no command outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("position", want.position, got.position);
               check_field("head_id", want.head_id, got.head_id);
               check_field("entry_count", want.entry_count, got.entry_count);
            end
         end
         if (req_tvalid && req_tready) begin
            moved        = 1'b1;
            req_accepted = 1'b1;
            want = apply_queue_command(
               req_tdata[uidq_pkg::CMD_W-1:0],
               req_tdata[uidq_pkg::CMD_W+uidq_pkg::ID_W-1:uidq_pkg::CMD_W]);
            expected_results.push_back(want);
            status_hits[want.status]++;
            commands_taken++;
            if (queued_model.size() > deepest_queue)
               deepest_queue = queued_model.size();
         end
         // no progress while work is outstanding
         if (moved) begin
            idle_cycles = 0;
         end else if (req_tvalid || expected_results.size() != 0 ||
                      pending_cmds.size() != 0) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("no beat moved for %0d cycles, %0d results outstanding",
                        idle_cycles, expected_results.size());
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int                         phase_left;
      int                         roll;
      cmd_mix_type                mix;
      logic [uidq_pkg::CMD_W-1:0] command;
      logic [uidq_pkg::ID_W-1:0]  plane_id;
      bit                         drain;

      // empty queue corners
      add_command(uidq_pkg::CMD_POP,    16'h0000, 1'b0);
      add_command(uidq_pkg::CMD_REMOVE, 16'h1234, 1'b0);
      add_command(uidq_pkg::CMD_QUERY,  16'h5678, 1'b0);
      // id extremes and duplicate
      add_command(uidq_pkg::CMD_APPEND, 16'h0000, 1'b0);
      add_command(uidq_pkg::CMD_APPEND, 16'hFFFF, 1'b0);
      add_command(uidq_pkg::CMD_APPEND, 16'hFFFF, 1'b0);
      // fill to the top, then full and duplicate-at-full
      for (int k = 0; k < uidq_pkg::QUEUE_DEPTH - 2; k++)
         add_command(uidq_pkg::CMD_APPEND, uidq_pkg::ID_W'(16'h1000 + k), 1'b0);
      add_command(uidq_pkg::CMD_APPEND, 16'hABCD, 1'b0);
      add_command(uidq_pkg::CMD_APPEND, 16'h0000, 1'b0);
      // last place, middle removal, head pop, tail removal
      add_command(uidq_pkg::CMD_QUERY,
                  uidq_pkg::ID_W'(16'h1000 + uidq_pkg::QUEUE_DEPTH - 3), 1'b0);
      add_command(uidq_pkg::CMD_REMOVE, 16'h1005, 1'b0);
      add_command(uidq_pkg::CMD_POP,    16'h0000, 1'b0);
      add_command(uidq_pkg::CMD_REMOVE,
                  uidq_pkg::ID_W'(16'h1000 + uidq_pkg::QUEUE_DEPTH - 3), 1'b1);

      // random phases drawing ids mostly from a small pool so hits are common
      foreach (id_pool[i])
         id_pool[i] = uidq_pkg::ID_W'($urandom);
      phase_left = 0;
      mix        = MIX_EVEN;
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         drain = 1'b0;
         if (phase_left == 0) begin
            phase_left = $urandom_range(30, 90);
            mix        = cmd_mix_type'($urandom_range(0, 2));
            drain      = ($urandom_range(0, 2) == 0);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL:  command = (roll < 65) ? uidq_pkg::CMD_APPEND :
                                 (roll < 75) ? uidq_pkg::CMD_REMOVE :
                                 (roll < 85) ? uidq_pkg::CMD_POP : uidq_pkg::CMD_QUERY;
            MIX_DRAIN: command = (roll < 15) ? uidq_pkg::CMD_APPEND :
                                 (roll < 50) ? uidq_pkg::CMD_REMOVE :
                                 (roll < 80) ? uidq_pkg::CMD_POP : uidq_pkg::CMD_QUERY;
            default:   command = (roll < 30) ? uidq_pkg::CMD_APPEND :
                                 (roll < 55) ? uidq_pkg::CMD_REMOVE :
                                 (roll < 75) ? uidq_pkg::CMD_POP : uidq_pkg::CMD_QUERY;
         endcase
         roll = $urandom_range(0, 19);
         if (roll < 15)
            plane_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
         else if (roll < 18)
            plane_id = uidq_pkg::ID_W'($urandom);
         else
            plane_id = (roll == 18) ? 16'h0000 : 16'hFFFF;
         // slow churn of the pool
         if ($urandom_range(0, 31) == 0)
            id_pool[$urandom_range(0, ID_POOL_SIZE - 1)] = uidq_pkg::ID_W'($urandom);
         add_command(command, plane_id, drain);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_cmds.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d commands and %0d results, queue reached %0d of %0d entries",
               commands_taken, results_seen, deepest_queue, uidq_pkg::QUEUE_DEPTH);
      $display("status mix: ok %0d, duplicate %0d, full %0d, not found %0d, empty %0d",
               status_hits[uidq_pkg::STAT_OK], status_hits[uidq_pkg::STAT_DUP],
               status_hits[uidq_pkg::STAT_FULL], status_hits[uidq_pkg::STAT_NOT_FOUND],
               status_hits[uidq_pkg::STAT_EMPTY]);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
